/* src/pps_pkg.sv */
// Shared constants, types and the arctangent table for the pure pursuit steering block.
// No dependencies; used by every module in src.
package pps_pkg;

    localparam int unsigned MaxWaypoints    = 1024;
    localparam int unsigned CordicIters     = 16;
    localparam int unsigned CordicW         = 40;
    localparam int unsigned InDataW         = 96;
    localparam int unsigned InUserW         = 2;
    localparam int unsigned OutDataW        = 48;
    localparam int unsigned CfgIdxW         = 8;
    localparam int unsigned CfgDataW        = 32;

    localparam logic [CfgIdxW-1:0] RegLookahead = 8'd0;
    localparam logic [CfgIdxW-1:0] RegWheelBase = 8'd1;
    localparam logic [CfgIdxW-1:0] RegTgtSpeed  = 8'd2;
    localparam logic [CfgIdxW-1:0] RegSpeedGain = 8'd3;

    localparam logic FuncLoad = 1'b0;
    localparam logic FuncTick = 1'b1;

    typedef enum logic [1:0] {
        PASS_BEAR,
        PASS_SIN,
        PASS_STEER
    } t_pass;

    typedef struct packed {
        logic  cap;
        logic  load;
        logic  th1;
        logic  th2;
        logic  th3;
        logic  empty;
        logic  rd_end;
        logic  rd_walk;
        logic  chk_end;
        logic  diff;
        logic  mul;
        logic  step;
        logic  hit;
        logic  settle;
        logic  c_start;
        logic  c_take;
        t_pass pass;
        logic  fin;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic empty;
        logic walk_end;
        logic far;
        logic c_done;
        logic c_busy;
    } t_sts;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] a;
        unique case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10680862;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            5'd30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

/* src/pps_cordic.sv */
// Iterative CORDIC unit, one micro-rotation per cycle, vectoring or rotation mode.
// Depends on pps_pkg for the arctangent table and the datapath width.
module pps_cordic #(
    parameter int unsigned ITER = pps_pkg::CordicIters
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic                                i_vec,
    input  logic signed [pps_pkg::CordicW-1:0]  i_x,
    input  logic signed [pps_pkg::CordicW-1:0]  i_y,
    input  logic        [31:0]                  i_ang,
    output logic                                o_busy,
    output logic                                o_done,
    output logic signed [pps_pkg::CordicW-1:0]  o_x,
    output logic signed [pps_pkg::CordicW-1:0]  o_y,
    output logic        [31:0]                  o_z
);
    import pps_pkg::*;

    localparam int unsigned CntW = $clog2(ITER);
    localparam logic signed [33:0] Quarter = 34'sh040000000;

    logic signed [CordicW-1:0] r_x, r_y, xs, ys;
    logic signed [33:0]        r_z, zs, za, a;
    logic [CntW-1:0]           r_cnt;
    logic                      r_busy, r_done, r_vec;

    assign zs = 34'(signed'(i_ang));
    assign za = 34'(signed'(i_ang ^ 32'h80000000));
    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;
    assign a  = signed'({2'b00, atan_entry(5'(r_cnt))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_vec <= i_vec;
                r_cnt <= '0;
                r_busy <= 1'b1;
                if (i_vec) begin
                    if (i_x == 0 && i_y == 0) begin
                        r_x <= '0;
                        r_y <= '0;
                        r_z <= '0;
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else if (i_x < 0) begin
                        r_x <= -i_x;
                        r_y <= -i_y;
                        r_z <= 34'sh080000000;
                    end else begin
                        r_x <= i_x;
                        r_y <= i_y;
                        r_z <= '0;
                    end
                end else begin
                    r_y <= '0;
                    if (zs > Quarter || zs < -Quarter) begin
                        r_x <= -i_x;
                        r_z <= za;
                    end else begin
                        r_x <= i_x;
                        r_z <= zs;
                    end
                end
            end else if (r_busy) begin
                if (r_vec ? !r_y[CordicW-1] : !r_z[33]) begin
                    if (r_vec) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + a;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - a;
                    end
                end else begin
                    if (r_vec) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - a;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + a;
                    end
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z[31:0];

endmodule

/* src/pps_dp.sv */
// Datapath: configuration registers, waypoint store, lookahead walk, throttle and CORDIC passes.
// Depends on pps_pkg and pps_cordic; driven by pps_ctrl through t_cmd.
module pps_dp #(
    parameter int unsigned MAXW = pps_pkg::MaxWaypoints,
    parameter int unsigned ITER = pps_pkg::CordicIters
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pps_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [pps_pkg::CfgDataW-1:0]     i_cfg_data,
    input  logic [pps_pkg::InDataW-1:0]      i_data,
    input  logic [pps_pkg::InUserW-1:0]      i_user,
    input  logic                             i_last,
    input  pps_pkg::t_cmd                    i_cmd,
    output pps_pkg::t_sts                    o_sts,
    output logic [pps_pkg::OutDataW-1:0]     o_data
);
    import pps_pkg::*;

    localparam int unsigned AW = $clog2(MAXW);
    localparam int unsigned CW = AW + 1;

    logic [30:0] r_look, r_wb;
    logic [15:0] r_ts, r_sg, r_head, r_vs;
    logic signed [31:0] r_px, r_py, r_goal_x, r_goal_y, r_prior_x, r_prior_y, r_lx, r_ly;
    logic r_first, r_last, r_active, r_goal, r_thr_en, r_big, r_big2;
    logic [CW-1:0] r_count, r_search;
    logic [63:0] mem [MAXW];
    logic [63:0] r_rd;
    logic [AW-1:0] rd_addr, wr_addr;
    logic wr_ok;
    logic [61:0] r_ld2, r_sx, r_sy;
    logic [30:0] r_ax, r_ay;
    logic signed [38:0] r_num, n2, m;
    logic [35:0] r_q;
    logic [17:0] u;
    logic [21:0] e24;
    logic signed [21:0] err;
    logic [15:0] r_thr, r_steer;
    logic [31:0] r_bear, r_ang3, neg3;
    logic signed [CordicW-1:0] r_mag, r_y2, c_x, c_y, co_x, co_y;
    logic [31:0] c_ang, co_z;
    logic c_vec, c_busy, c_done;
    logic signed [32:0] dx, dy, ax, ay;
    logic [62:0] sum;
    logic [OutDataW-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_look <= 31'd327680;
            r_wb   <= 31'd131072;
            r_ts   <= 16'd128;
            r_sg   <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                RegLookahead: r_look <= i_cfg_data[30:0];
                RegWheelBase: r_wb   <= i_cfg_data[30:0];
                RegTgtSpeed:  r_ts   <= i_cfg_data[15:0];
                RegSpeedGain: r_sg   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign wr_addr = r_first ? '0 : r_count[AW-1:0];
    assign wr_ok   = r_first || (r_count < CW'(MAXW));
    assign rd_addr = i_cmd.rd_end ? AW'(r_count - 1'b1) : r_search[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && wr_ok) begin
            mem[wr_addr] <= {r_py, r_px};
        end
        if (i_cmd.rd_end || i_cmd.rd_walk) begin
            r_rd <= mem[rd_addr];
        end
    end

    assign e24 = {2'b00, r_ts, 4'b0000} + {3'b000, r_ts, 3'b000};
    assign err = signed'(e24 - {6'b0, r_vs});
    assign n2  = r_num + 39'sd192;
    assign m   = n2 >>> 7;
    always_comb begin
        if (m > 39'sd98303) begin
            u = 18'd196607;
        end else if (m < -39'sd98304) begin
            u = 18'd0;
        end else begin
            u = 18'(m + 39'sd98304);
        end
    end

    assign dx  = 33'(signed'(r_rd[31:0])) - 33'(r_px);
    assign dy  = 33'(signed'(r_rd[63:32])) - 33'(r_py);
    assign ax  = dx[32] ? -dx : dx;
    assign ay  = dy[32] ? -dy : dy;
    assign sum = {1'b0, r_sx} + {1'b0, r_sy};

    always_comb begin
        c_x   = '0;
        c_y   = '0;
        c_ang = '0;
        c_vec = 1'b1;
        unique case (i_cmd.pass)
            PASS_BEAR: begin
                c_x = CordicW'(33'(r_goal_x) - 33'(r_px));
                c_y = CordicW'(33'(r_goal_y) - 33'(r_py));
            end
            PASS_SIN: begin
                c_x   = signed'(CordicW'({r_wb, 1'b0}));
                c_ang = r_bear - {r_head, 16'h0000};
                c_vec = 1'b0;
            end
            PASS_STEER: begin
                c_x = r_mag;
                c_y = r_y2;
            end
            default: ;
        endcase
    end

    pps_cordic #(.ITER(ITER)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.c_start),
        .i_vec   (c_vec),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_ang   (c_ang),
        .o_busy  (c_busy),
        .o_done  (c_done),
        .o_x     (co_x),
        .o_y     (co_y),
        .o_z     (co_z)
    );

    assign neg3 = (32'd0 - r_ang3) + 32'h00008000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_search  <= '0;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_prior_x <= '0;
            r_prior_y <= '0;
            r_active  <= 1'b0;
            r_goal    <= 1'b0;
        end else begin
            if (i_cmd.cap) begin
                r_px    <= signed'(i_data[31:0]);
                r_py    <= signed'(i_data[63:32]);
                r_head  <= i_data[79:64];
                r_vs    <= i_data[95:80];
                r_first <= i_user[1];
                r_last  <= i_last;
            end
            if (i_cmd.load) begin
                if (wr_ok) begin
                    r_count <= CW'(wr_addr) + 1'b1;
                end else if (r_first) begin
                    r_count <= '0;
                end
                if (r_last) begin
                    r_active <= 1'b1;
                end
            end
            if (i_cmd.th1) begin
                r_num    <= signed'({1'b0, r_sg}) * err;
                r_ld2    <= r_look * r_look;
                r_thr_en <= r_active && !r_goal;
                r_steer  <= '0;
            end
            if (i_cmd.th2) begin
                r_q <= u * 18'd174763;
            end
            if (i_cmd.th3) begin
                r_thr <= r_thr_en ? (r_q[34:19] ^ 16'h8000) : 16'h0000;
            end
            if (i_cmd.empty) begin
                r_search <= '0;
                r_goal   <= 1'b1;
                r_active <= 1'b0;
            end
            if (i_cmd.chk_end) begin
                r_lx <= signed'(r_rd[31:0]);
                r_ly <= signed'(r_rd[63:32]);
                if (r_rd != {r_prior_y, r_prior_x}) begin
                    r_search <= '0;
                end
            end
            if (i_cmd.diff) begin
                r_big <= ax[32] | ax[31] | ay[32] | ay[31];
                r_ax  <= ax[30:0];
                r_ay  <= ay[30:0];
            end
            if (i_cmd.mul) begin
                r_sx   <= r_ax * r_ax;
                r_sy   <= r_ay * r_ay;
                r_big2 <= r_big;
            end
            if (i_cmd.step) begin
                r_search <= r_search + 1'b1;
            end
            if (i_cmd.hit) begin
                r_goal_x <= signed'(r_rd[31:0]);
                r_goal_y <= signed'(r_rd[63:32]);
            end
            if (i_cmd.settle) begin
                r_goal   <= ({1'b0, r_search} + 3'd3) > {1'b0, r_count};
                r_active <= !(({1'b0, r_search} + 3'd3) > {1'b0, r_count});
            end
            if (i_cmd.c_take) begin
                unique case (i_cmd.pass)
                    PASS_BEAR: begin
                        r_bear <= co_z;
                        r_mag  <= co_x;
                    end
                    PASS_SIN:   r_y2   <= co_y;
                    PASS_STEER: r_ang3 <= co_z;
                    default: ;
                endcase
            end
            if (i_cmd.fin) begin
                r_steer   <= neg3[31:16];
                r_prior_x <= r_lx;
                r_prior_y <= r_ly;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= {3'b000, 11'(r_search), r_goal, r_goal, r_thr, r_steer};
        end
    end

    assign o_sts.active   = r_active;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.walk_end = (r_search >= r_count);
    assign o_sts.far      = r_big2 || (sum >= {1'b0, r_ld2});
    assign o_sts.c_done   = c_done;
    assign o_sts.c_busy   = c_busy;
    assign o_data         = r_out;

endmodule

/* src/pps_ctrl.sv */
// Controller state machine: input and output handshakes, sequencing of the datapath.
// Depends on pps_pkg for the command and status structs.
module pps_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_func,
    output logic           o_s_tready,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    input  pps_pkg::t_sts  i_sts,
    output pps_pkg::t_cmd  o_cmd
);
    import pps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_TH1, S_TH2, S_TH3, S_END_RD, S_END_CHK, S_W_RD,
        S_W_DIF, S_W_MUL, S_W_CMP, S_SETTLE, S_C_GO, S_C_WAIT, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    t_pass  r_pass;
    logic   r_m_valid;
    logic   room;

    assign room       = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        unique case (r_state)
            S_IDLE:    o_cmd.cap = i_s_tvalid;
            S_LOAD:    o_cmd.load = 1'b1;
            S_TH1:     o_cmd.th1 = 1'b1;
            S_TH2:     o_cmd.th2 = 1'b1;
            S_TH3: begin
                o_cmd.th3   = 1'b1;
                o_cmd.empty = i_sts.active && i_sts.empty;
            end
            S_END_RD:  o_cmd.rd_end = 1'b1;
            S_END_CHK: o_cmd.chk_end = 1'b1;
            S_W_RD:    o_cmd.rd_walk = !i_sts.walk_end;
            S_W_DIF:   o_cmd.diff = 1'b1;
            S_W_MUL:   o_cmd.mul = 1'b1;
            S_W_CMP: begin
                o_cmd.hit  = i_sts.far;
                o_cmd.step = !i_sts.far;
            end
            S_SETTLE:  o_cmd.settle = 1'b1;
            S_C_GO:    o_cmd.c_start = 1'b1;
            S_C_WAIT:  o_cmd.c_take = i_sts.c_done;
            S_FIN:     o_cmd.fin = 1'b1;
            S_OUT:     o_cmd.out_load = room;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pass    <= PASS_BEAR;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && room) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_state <= (i_func == FuncLoad) ? S_LOAD : S_TH1;
                    end
                end
                S_LOAD: r_state <= S_IDLE;
                S_TH1:  r_state <= S_TH2;
                S_TH2:  r_state <= S_TH3;
                S_TH3: begin
                    if (!i_sts.active || i_sts.empty) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_END_RD;
                    end
                end
                S_END_RD:  r_state <= S_END_CHK;
                S_END_CHK: r_state <= S_W_RD;
                S_W_RD:    r_state <= i_sts.walk_end ? S_SETTLE : S_W_DIF;
                S_W_DIF:   r_state <= S_W_MUL;
                S_W_MUL:   r_state <= S_W_CMP;
                S_W_CMP:   r_state <= i_sts.far ? S_SETTLE : S_W_RD;
                S_SETTLE: begin
                    r_pass  <= PASS_BEAR;
                    r_state <= S_C_GO;
                end
                S_C_GO:    r_state <= S_C_WAIT;
                S_C_WAIT: begin
                    if (i_sts.c_done) begin
                        priority case (r_pass)
                            PASS_BEAR: begin
                                r_pass  <= PASS_SIN;
                                r_state <= S_C_GO;
                            end
                            PASS_SIN: begin
                                r_pass  <= PASS_STEER;
                                r_state <= S_C_GO;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_FIN: r_state <= S_OUT;
                S_OUT: begin
                    if (room) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* src/pure_pursuit_steering_top.sv */
// Pure pursuit steering block: top level joining controller and datapath.
// Depends on pps_pkg, pps_ctrl, pps_dp (and pps_cordic below it).
//
// Input stream: tuser[0] selects waypoint load (0) or control tick (1), tuser[1] starts
// a new path, tlast marks its final waypoint. Loads give no result; a tick gives one.
// Configuration: one register write per transfer on the cfg channel, always ready;
// write only while the block is idle.
// Flow: one item at a time. A load is captured and then written to the waypoint store.
// A tick on an inactive or empty path computes the throttle and skips the walk and the
// CORDIC passes. An active tick also walks the waypoint store (one read port; read,
// difference, square and compare steps for each entry examined) and then makes the three
// passes of the single iterative CORDIC unit; a pass on a zero vector ends early.
// The result sits in an output register, so the next item is accepted while it waits;
// a stalled receiver holds the block only when a further result is ready to leave.
// Reset clears the path count, search index, goal and flags and restores register defaults;
// the waypoint store is not cleared and needs no clearing pass.
module pure_pursuit_steering_top #(
    parameter int unsigned MAX_WAYPOINTS     = pps_pkg::MaxWaypoints,
    parameter int unsigned CORDIC_ITERATIONS = pps_pkg::CordicIters
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], vehicle_speed[95:80]
    input  logic [pps_pkg::InDataW-1:0]       i_s_tdata,
    // func[0], path_first[1]
    input  logic [pps_pkg::InUserW-1:0]       i_s_tuser,
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // steer[15:0], throttle[31:16], brake[32], goal_reached[33],
    // target_index[44:34], zero[47:45]
    output logic [pps_pkg::OutDataW-1:0]      o_m_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pps_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [pps_pkg::CfgDataW-1:0]      i_cfg_data
);
    import pps_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    pps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_func     (i_s_tuser[0]),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pps_dp #(
        .MAXW (MAX_WAYPOINTS),
        .ITER (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_data      (i_s_tdata),
        .i_user      (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_data      (o_m_tdata)
    );

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_brake_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[32] == o_m_tdata[33])
        else $error("brake and goal disagree");

    a_idle_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_sts.c_busy)
        else $error("input ready while CORDIC busy");

    a_cap_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.cap |-> o_s_tready && i_s_tvalid)
        else $error("capture outside a transfer");

endmodule
